### hw/rtl/rtp_pkg.sv
// ----------------------------------------------------------------------------
// rtp_pkg
// shared types, constants and helpers for the rgb to terminal palette block
// ----------------------------------------------------------------------------
package rtp_pkg;

  typedef enum logic [1:0] {
    MODE_TWO     = 2'd0,
    MODE_SIXTEEN = 2'd1,
    MODE_PALETTE = 2'd2,
    MODE_DIRECT  = 2'd3
  } rtp_mode_e;

  // stage load enables from the pipeline control
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } rtp_adv_t;

  localparam int unsigned PixW     = 24;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned OutDataW = IdxW + 3 * ChanW;

  localparam int unsigned GreyQW   = 5;
  localparam int unsigned GreyProdW = 23;
  localparam logic [13:0] GreyRecip = 14'd12340;
  localparam int unsigned GreyShift = 18;
  localparam logic [GreyQW-1:0] GreySteps = 5'd24;
  localparam logic [IdxW-1:0] GreyBase = 8'd232;
  localparam logic [IdxW-1:0] GreyTop  = 8'd255;
  localparam logic [IdxW-1:0] CubeBase = 8'd16;
  localparam logic [IdxW-1:0] CubeRedW = 8'd36;
  localparam logic [IdxW-1:0] CubeGrnW = 8'd6;

  // level of one channel on the 6-step cube axis
  function automatic logic [2:0] cube_level(logic [ChanW-1:0] c);
    logic [2:0] lvl;
    lvl = 3'd0;
    if (c >= 8'd56) lvl = 3'd1;
    if (c >= 8'd96) lvl = 3'd2;
    if (c >= 8'd136) lvl = 3'd3;
    if (c >= 8'd176) lvl = 3'd4;
    if (c >= 8'd216) lvl = 3'd5;
    return lvl;
  endfunction

endpackage

### hw/rtl/rtp_core.sv
// ----------------------------------------------------------------------------
// rtp_core
// pixel datapath: capture, min/max and cube levels, grey test and ramp
// step, final code select
// ----------------------------------------------------------------------------
module rtp_core (
  input  logic                          clk_i,
  input  rtp_pkg::rtp_adv_t             adv_i,
  input  rtp_pkg::rtp_mode_e            mode_i,
  input  logic [rtp_pkg::PixW-1:0]      pixel_i,
  input  logic                          last_i,
  output logic [rtp_pkg::OutDataW-1:0]  data_o,
  output logic                          last_o
);
  import rtp_pkg::*;

  // stage 1
  rtp_mode_e         mode1_q;
  logic [PixW-1:0]   pix1_q;
  logic              last1_q;

  // stage 2
  rtp_mode_e         mode2_q;
  logic [PixW-1:0]   pix2_q;
  logic              last2_q;
  logic [ChanW-1:0]  hi2_q, lo2_q;
  logic [2:0]        lvr2_q, lvg2_q, lvb2_q;
  logic [2:0]        simple2_q;
  logic [ChanW-1:0]  hi2_d, lo2_d;
  logic [2:0]        simple2_d;

  // stage 3
  rtp_mode_e         mode3_q;
  logic [PixW-1:0]   pix3_q;
  logic              last3_q;
  logic [2:0]        simple3_q;
  logic              grey3_q;
  logic [IdxW-1:0]   cube3_q;
  logic [GreyQW-1:0] q3_q;
  logic              grey3_d;
  logic [IdxW-1:0]   cube3_d;
  logic [ChanW:0]    sum3;
  logic [GreyProdW-1:0] prod3;
  logic [ChanW-1:0]  diff3;

  // stage 4
  logic [OutDataW-1:0] data4_q, data4_d;
  logic                last4_q;
  logic [IdxW-1:0]     idx4;

  logic [ChanW-1:0] r1, g1, b1;

  assign r1 = pix1_q[23:16];
  assign g1 = pix1_q[15:8];
  assign b1 = pix1_q[7:0];

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      mode1_q <= mode_i;
      pix1_q  <= pixel_i;
      last1_q <= last_i;
    end
  end

  always_comb begin
    hi2_d = r1;
    lo2_d = r1;
    if (g1 > hi2_d) hi2_d = g1;
    if (b1 > hi2_d) hi2_d = b1;
    if (g1 < lo2_d) lo2_d = g1;
    if (b1 < lo2_d) lo2_d = b1;
    case (mode1_q)
      MODE_TWO:     simple2_d = {2'b00, (pix1_q != '0)};
      MODE_SIXTEEN: simple2_d = {b1[7], g1[7], r1[7]};
      default:      simple2_d = 3'd0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s2) begin
      mode2_q   <= mode1_q;
      pix2_q    <= pix1_q;
      last2_q   <= last1_q;
      hi2_q     <= hi2_d;
      lo2_q     <= lo2_d;
      lvr2_q    <= cube_level(r1);
      lvg2_q    <= cube_level(g1);
      lvb2_q    <= cube_level(b1);
      simple2_q <= simple2_d;
    end
  end

  // grey when (hi - lo) * 256 / hi < 32, i.e. (hi - lo) * 8 < hi
  always_comb begin
    diff3   = hi2_q - lo2_q;
    grey3_d = (hi2_q == '0) || ({diff3, 3'b000} < {3'b000, hi2_q});
    sum3    = {1'b0, hi2_q} + {1'b0, lo2_q};
    prod3   = GreyProdW'(sum3) * GreyProdW'(GreyRecip);
    cube3_d = CubeBase + IdxW'(lvr2_q) * CubeRedW + IdxW'(lvg2_q) * CubeGrnW
              + IdxW'(lvb2_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s3) begin
      mode3_q   <= mode2_q;
      pix3_q    <= pix2_q;
      last3_q   <= last2_q;
      simple3_q <= simple2_q;
      grey3_q   <= grey3_d;
      cube3_q   <= cube3_d;
      q3_q      <= prod3[GreyShift +: GreyQW];
    end
  end

  always_comb begin
    idx4 = '0;
    if (grey3_q) begin
      idx4 = (q3_q == GreySteps) ? GreyTop : GreyBase + IdxW'(q3_q);
    end else begin
      idx4 = cube3_q;
    end
    case (mode3_q)
      MODE_TWO, MODE_SIXTEEN: data4_d = {24'd0, 5'd0, simple3_q};
      MODE_PALETTE:           data4_d = {24'd0, idx4};
      MODE_DIRECT:            data4_d = {pix3_q[7:0], pix3_q[15:8], pix3_q[23:16], 8'd0};
      default:                data4_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      data4_q <= data4_d;
      last4_q <= last3_q;
    end
  end

  assign data_o = data4_q;
  assign last_o = last4_q;

endmodule

### hw/rtl/rgb_to_terminal_palette_top.sv
// ----------------------------------------------------------------------------
// rgb_to_terminal_palette_top
// maps a 24-bit rgb pixel stream to terminal color codes in the selected mode
// ----------------------------------------------------------------------------
// One pixel per clock in and out while the output side is ready. Each pixel
// passes four register stages (capture, min/max and cube levels, grey test
// with ramp multiply, code select); a result is registered in the last stage
// and, when the output side is ready, transfers at the following edge.
// Backpressure stalls a full stage only when the stage after it is stalled;
// bubbles are squeezed out. The color mode is sampled with each pixel as it enters.
module rgb_to_terminal_palette_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_data_i,     // color_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // pixel_rgb[23:0]
  input  logic        s_axis_tlast,   // row_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // palette_index, red_out, green_out, blue_out
  output logic        m_axis_tlast    // row_done
);
  import rtp_pkg::*;

  rtp_mode_e mode_q;
  logic      v1_q, v2_q, v3_q, v4_q;
  logic      rdy1, rdy2, rdy3, rdy4;
  rtp_adv_t  adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_TWO;
    end else if (cfg_we_i) begin
      mode_q <= rtp_mode_e'(cfg_data_i);
    end
  end

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign adv.s1 = rdy1;
  assign adv.s2 = rdy2;
  assign adv.s3 = rdy3;
  assign adv.s4 = rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  rtp_core u_core (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .mode_i  (mode_q),
    .pixel_i (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .data_o  (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v4_q;

endmodule

### sim/rgb_to_terminal_palette_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_terminal_palette_top_tb
// self-checking bench for the rgb to terminal palette block
// ----------------------------------------------------------------------------
// Pixels stream in with random bursts and gaps while the output side stalls
// on its own pattern. Every pixel accepted is mapped to its expected color code
// and channel values for the current color mode, and each result transfer is
// checked in order against those. The color mode changes only when the block
// has drained. A directed pass covers the mode extremes, the grey threshold,
// the cube level edges and the white clamp; random pixels follow in all modes.
module rgb_to_terminal_palette_top_tb;
  import rtp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic [7:0] code;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_done;
  } color_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_data_i = 2'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = 24'd0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  color_result_t expected_colors[$];
  rtp_mode_e     active_mode = MODE_TWO;
  int unsigned   fail_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   burst_left = 0;
  int unsigned   tx_max_gap = 0;
  int unsigned   rx_style = 0;
  int unsigned   rx_stall_pct = 0;
  int unsigned   rx_phase = 0;

  rgb_to_terminal_palette_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int unsigned cube_step(logic [7:0] c);
    if (c < 8'd55) return 0;
    return (int'(c) - 16) / 40;
  endfunction

  function automatic logic [7:0] palette_lookup(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned hi, lo, sat, code;
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    sat = (hi == 0) ? 0 : ((hi - lo) * 256) / hi;
    if (sat < 32) begin
      code = 232 + ((hi + lo) * 24) / 510;
      if (code > 255) code = 255;
    end else begin
      code = 16 + 36 * cube_step(r) + 6 * cube_step(g) + cube_step(b);
    end
    return code[7:0];
  endfunction

  function automatic color_result_t predict_color(rtp_mode_e mode, logic [23:0] pix,
                                                  logic last);
    color_result_t res;
    logic [7:0] r, g, b;
    r = pix[23:16];
    g = pix[15:8];
    b = pix[7:0];
    res = '0;
    res.row_done = last;
    case (mode)
      MODE_TWO: begin
        res.code = (pix != 24'd0) ? 8'd1 : 8'd0;
      end
      MODE_SIXTEEN: begin
        res.code = {5'd0, b[7], g[7], r[7]};
      end
      MODE_PALETTE: begin
        res.code = palette_lookup(r, g, b);
      end
      default: begin
        res.red   = r;
        res.green = g;
        res.blue  = b;
      end
    endcase
    return res;
  endfunction

  // output side stall pattern
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 1;
    case (rx_style)
      1: m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      2: m_axis_tready <= ((rx_phase % 11) >= 4);
      default: m_axis_tready <= 1'b1;
    endcase
  end

  // result checker
  always @(posedge clk_i) begin
    color_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_colors.size() == 0) begin
        $error("result transfer with no pixel pending: tdata %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_colors.pop_front();
        if (m_axis_tdata[7:0] !== want.code) begin
          $error("palette_index expected %0d got %0d", want.code, m_axis_tdata[7:0]);
          fail_count++;
        end
        if (m_axis_tdata[15:8] !== want.red) begin
          $error("red_out expected %0d got %0d", want.red, m_axis_tdata[15:8]);
          fail_count++;
        end
        if (m_axis_tdata[23:16] !== want.green) begin
          $error("green_out expected %0d got %0d", want.green, m_axis_tdata[23:16]);
          fail_count++;
        end
        if (m_axis_tdata[31:24] !== want.blue) begin
          $error("blue_out expected %0d got %0d", want.blue, m_axis_tdata[31:24]);
          fail_count++;
        end
        if (m_axis_tlast !== want.row_done) begin
          $error("row_done expected %0d got %0d", want.row_done, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  task automatic send_pixel(input logic [23:0] pix, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_colors.push_back(predict_color(active_mode, pix, last));
  endtask

  task automatic wait_drained();
    while (expected_colors.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_mode(input rtp_mode_e mode);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    wait_drained();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    active_mode = mode;
  endtask

  function automatic logic [7:0] edge_channel();
    logic [7:0] picks[16] = '{8'd0, 8'd54, 8'd55, 8'd56, 8'd95, 8'd96, 8'd127, 8'd128,
                              8'd135, 8'd136, 8'd175, 8'd176, 8'd215, 8'd216, 8'd254,
                              8'd255};
    return picks[$urandom_range(0, 15)];
  endfunction

  function automatic logic [7:0] near_level(int base);
    int v;
    v = base + int'($urandom_range(0, 20)) - 10;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic logic [23:0] random_pixel();
    int base;
    base = $urandom_range(0, 255);
    case ($urandom_range(0, 3))
      0: return {near_level(base), near_level(base), near_level(base)};
      1: return {edge_channel(), edge_channel(), edge_channel()};
      default: return 24'($urandom_range(0, 24'hffffff));
    endcase
  endfunction

  task automatic test_two_color();
    set_mode(MODE_TWO);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hffffff, 1'b0);
    send_pixel(24'h000001, 1'b1);
    send_pixel(24'h800000, 1'b0);
  endtask

  task automatic test_sixteen_color();
    set_mode(MODE_SIXTEEN);
    send_pixel(24'h7f7f7f, 1'b0);
    send_pixel(24'h808080, 1'b0);
    send_pixel(24'h800000, 1'b0);
    send_pixel(24'h008000, 1'b1);
    send_pixel(24'h000080, 1'b0);
  endtask

  task automatic test_palette_map();
    set_mode(MODE_PALETTE);
    send_pixel(24'h000000, 1'b0);
    send_pixel(24'hffffff, 1'b0);   // white clamps to top of ramp
    send_pixel(24'h808080, 1'b0);
    send_pixel(24'h646458, 1'b1);   // just under grey threshold
    send_pixel(24'h646457, 1'b0);   // just over grey threshold
    send_pixel(24'h370000, 1'b0);
    send_pixel(24'h380000, 1'b0);
    send_pixel(24'h00ff00, 1'b0);
    send_pixel(24'h0000ff, 1'b1);
  endtask

  task automatic test_direct_color();
    set_mode(MODE_DIRECT);
    send_pixel(24'h123456, 1'b0);
    send_pixel(24'hffffff, 1'b1);
    send_pixel(24'h000000, 1'b0);
  endtask

  task automatic test_random_stream();
    rtp_mode_e mode;
    for (int chunk = 0; chunk < 20; chunk++) begin
      mode = (chunk < 4) ? rtp_mode_e'(chunk) : rtp_mode_e'($urandom_range(0, 3));
      set_mode(mode);
      tx_max_gap   = (chunk % 5 == 0) ? 0 : $urandom_range(1, 8);
      rx_style     = (chunk % 3 == 0) ? 0 : $urandom_range(1, 2);
      rx_stall_pct = $urandom_range(10, 70);
      for (int n = 0; n < 50; n++) begin
        send_pixel(random_pixel(), ($urandom_range(0, 7) == 0));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_max_gap = 3;
    rx_style = 1;
    rx_stall_pct = 30;
    test_two_color();
    test_sixteen_color();
    test_palette_map();
    test_direct_color();
    test_random_stream();
    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
